FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/lcfs_pkg.sv
package lcfs_pkg;

	localparam int unsigned COLUMNS_DEF = 200;
	localparam int unsigned BITS_PER_LINE_DEF = 8;

	localparam int unsigned OP_W = 3;
	localparam int unsigned COL_W = 8;
	localparam int unsigned BIT_W = 4;
	localparam int unsigned WORD_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_WR_PIX = 3'd0,
		OP_WR_COL = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_START  = 3'd3,
		OP_TICK   = 3'd4,
		OP_RD_PIX = 3'd5,
		OP_SET_EN = 3'd6,
		OP_NOP    = 3'd7
	} op_t;

	// Per-command scan information, taken at the transfer of the command.
	typedef struct packed {
		logic             strobe;
		logic             load;
		logic [BIT_W-1:0] dl_pos;
		logic [BIT_W-1:0] dh_pos;
		logic             dh_ok;
		logic             latch;
		logic             enable;
		logic             busy;
	} scan_info_t;

endpackage

FILE: sv/lcfs_cmd_if.sv
interface lcfs_cmd_if;
	import lcfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [COL_W-1:0]  column_index;
	logic [BIT_W-1:0]  bit_index;
	logic [WORD_W-1:0] write_value;

	modport source (output valid, opcode, column_index, bit_index, write_value, input ready);
	modport sink (input valid, opcode, column_index, bit_index, write_value, output ready);
endinterface

FILE: sv/lcfs_res_if.sv
interface lcfs_res_if;
	logic valid;
	logic ready;
	logic read_bit;
	logic serial_lo;
	logic serial_hi;
	logic shift_strobe;
	logic latch_level;
	logic output_enable;
	logic busy_res;

	modport source (output valid, read_bit, serial_lo, serial_hi, shift_strobe, latch_level,
		output_enable, busy_res, input ready);
	modport sink (input valid, read_bit, serial_lo, serial_hi, shift_strobe, latch_level,
		output_enable, busy_res, output ready);
endinterface

FILE: sv/lcfs_frame_mem.sv
module lcfs_frame_mem #(
	parameter int unsigned DEPTH = lcfs_pkg::COLUMNS_DEF,
	parameter int unsigned AW = $clog2(lcfs_pkg::COLUMNS_DEF)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lcfs_pkg::WORD_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [lcfs_pkg::WORD_W-1:0] rdata
);
	import lcfs_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/lcfs_clr_sweep.sv
module lcfs_clr_sweep #(
	parameter int unsigned COLUMNS = lcfs_pkg::COLUMNS_DEF,
	parameter int unsigned AW = $clog2(lcfs_pkg::COLUMNS_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          active,
	output logic [AW-1:0] addr
);
	import lcfs_pkg::*;

	logic          active_q;
	logic [AW-1:0] addr_q;

	// Sweep runs out of reset and again on every clear command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			if (addr_q == AW'(COLUMNS - 1)) begin
				active_q <= 1'b0;
				addr_q   <= '0;
			end else begin
				addr_q <= addr_q + 1'b1;
			end
		end else if (start) begin
			active_q <= 1'b1;
		end
	end

	assign active = active_q;
	assign addr   = addr_q;
endmodule

FILE: sv/lcfs_scan_seq.sv
module lcfs_scan_seq #(
	parameter int unsigned COLUMNS = lcfs_pkg::COLUMNS_DEF,
	parameter int unsigned BITS_PER_LINE = lcfs_pkg::BITS_PER_LINE_DEF,
	parameter int unsigned AW = $clog2(lcfs_pkg::COLUMNS_DEF),
	parameter int unsigned SBW = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  lcfs_pkg::op_t        op,
	input  logic                 en_val,
	output logic [AW-1:0]        column,
	output lcfs_pkg::scan_info_t info
);
	import lcfs_pkg::*;

	logic           active_q, active_d;
	logic [AW-1:0]  col_q, col_d;
	logic [SBW-1:0] bit_q, bit_d;
	logic           latch_q, latch_d;
	logic           enable_q, enable_d;
	logic [BIT_W:0] dh_sum;

	always_comb begin
		active_d = active_q;
		col_d    = col_q;
		bit_d    = bit_q;
		latch_d  = latch_q;
		enable_d = enable_q;
		case (op)
			OP_START: begin
				if (!active_q) begin
					active_d = 1'b1;
					col_d    = '0;
					bit_d    = '0;
					latch_d  = 1'b0;
					enable_d = 1'b1;
				end
			end
			OP_TICK: begin
				if (active_q) begin
					enable_d = 1'b1;
					if (bit_q == SBW'(BITS_PER_LINE - 1)) begin
						bit_d = '0;
						if (col_q == AW'(COLUMNS - 1)) begin
							col_d    = '0;
							active_d = 1'b0;
							latch_d  = 1'b1;
						end else begin
							col_d = col_q + 1'b1;
						end
					end else begin
						bit_d = bit_q + 1'b1;
					end
				end
			end
			OP_SET_EN: enable_d = en_val;
			default: ;
		endcase

		dh_sum       = (BIT_W + 1)'(bit_q) + (BIT_W + 1)'(BITS_PER_LINE);
		info.strobe  = (op == OP_TICK) && active_q;
		info.load    = info.strobe && (bit_q == '0);
		info.dl_pos  = BIT_W'(bit_q);
		info.dh_pos  = dh_sum[BIT_W-1:0];
		info.dh_ok   = !dh_sum[BIT_W];
		info.latch   = latch_d;
		info.enable  = enable_d;
		info.busy    = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			bit_q    <= '0;
			latch_q  <= 1'b1;
			enable_q <= 1'b1;
		end else if (accept) begin
			active_q <= active_d;
			col_q    <= col_d;
			bit_q    <= bit_d;
			latch_q  <= latch_d;
			enable_q <= enable_d;
		end
	end

	assign column = col_q;
endmodule

FILE: sv/led_column_frame_shifter_unit.sv
// Channel | Dir | Payload
// cmd     | in  | opcode, column_index, bit_index, write_value
// res     | out | read_bit, serial_lo, serial_hi, shift_strobe, latch_level,
//         |     | output_enable, busy_res
//
// One command per cycle while no clear sweep runs and res takes each result; its result
// passes the stage-1 registers (frame memory read at the transfer edge), then the output register.
// Each command reads the frame memory once and writes back at most once
// through a single write port.
// Reset and every clear command start a sweep that zeroes every column of
// the frame memory; cmd.ready stays low during it.
// A stalled res side holds the result register and backs up into cmd.ready.
module led_column_frame_shifter_unit #(
	parameter int unsigned COLUMNS = lcfs_pkg::COLUMNS_DEF,
	parameter int unsigned BITS_PER_LINE = lcfs_pkg::BITS_PER_LINE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lcfs_cmd_if.sink   cmd,
	lcfs_res_if.source res
);
	import lcfs_pkg::*;

	localparam int unsigned AW  = $clog2(COLUMNS);
	localparam int unsigned SBW = (BITS_PER_LINE > 1) ? $clog2(BITS_PER_LINE) : 1;

	// Front side: command transfer, memory read issue, scan sequencing.
	op_t           op_in;
	logic          accept;
	logic          col_ok;
	logic [AW-1:0] scan_col;
	logic [AW-1:0] rd_addr;
	scan_info_t    info;
	logic          clr_active;
	logic [AW-1:0] clr_addr;

	// Stage 1: memory data back, modify, write back.
	logic              s1_valid_q;
	op_t               op_s1;
	logic [AW-1:0]     col_s1;
	logic              col_ok_s1;
	logic [BIT_W-1:0]  bit_s1;
	logic [WORD_W-1:0] val_s1;
	scan_info_t        info_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_data_s1;
	logic              s1_adv;
	logic              s1_we;
	logic [WORD_W-1:0] s1_wdata;
	logic [WORD_W-1:0] mem_rdata;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] shift_q;
	logic              rd_bit;
	logic              dl_bit;
	logic              dh_bit;

	// Memory port muxing.
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	// Output register.
	logic out_valid_q;
	logic read_bit_q, serial_lo_q, serial_hi_q, strobe_q, latch_q, enable_q, busy_q;

	assign op_in     = op_t'(cmd.opcode);
	assign col_ok    = 32'(cmd.column_index) < 32'(COLUMNS);
	assign s1_adv    = s1_valid_q && (!out_valid_q || res.ready);
	assign cmd.ready = !clr_active && (!s1_valid_q || s1_adv);
	assign accept    = cmd.valid && cmd.ready;

	// Tick reads the column being scanned, everything else reads its address.
	assign rd_addr = (op_in == OP_TICK) ? scan_col : AW'(cmd.column_index);

	lcfs_scan_seq #(
		.COLUMNS      (COLUMNS),
		.BITS_PER_LINE(BITS_PER_LINE),
		.AW           (AW),
		.SBW          (SBW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.op    (op_in),
		.en_val(cmd.write_value != '0),
		.column(scan_col),
		.info  (info)
	);

	lcfs_clr_sweep #(
		.COLUMNS(COLUMNS),
		.AW     (AW)
	) u_clr (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && (op_in == OP_CLEAR)),
		.active(clr_active),
		.addr  (clr_addr)
	);

	// Sweep owns the write port while it runs; stage 1 then holds at most the clear command, which writes nothing.
	assign mem_we    = clr_active || (s1_adv && s1_we);
	assign mem_waddr = clr_active ? clr_addr : col_s1;
	assign mem_wdata = clr_active ? '0 : s1_wdata;

	lcfs_frame_mem #(
		.DEPTH(COLUMNS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Capture the command and forward a write-back that lands on the same
	// entry in the cycle the read is issued.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			col_s1      <= AW'(cmd.column_index);
			col_ok_s1   <= col_ok;
			bit_s1      <= cmd.bit_index;
			val_s1      <= cmd.write_value;
			info_s1     <= info;
			fwd_s1      <= s1_adv && s1_we && (col_s1 == rd_addr);
			fwd_data_s1 <= s1_wdata;
		end
	end

	assign word     = fwd_s1 ? fwd_data_s1 : mem_rdata;
	assign cur_word = info_s1.load ? word : shift_q;
	assign mask     = WORD_W'(1) << bit_s1;

	// Read-modify-write of the addressed column.
	always_comb begin
		s1_we    = 1'b0;
		s1_wdata = word;
		case (op_s1)
			OP_WR_PIX: begin
				s1_we    = col_ok_s1;
				s1_wdata = (val_s1 != '0) ? (word | mask) : (word & ~mask);
			end
			OP_WR_COL: begin
				s1_we    = col_ok_s1;
				s1_wdata = val_s1;
			end
			default: ;
		endcase
	end

	assign rd_bit = (op_s1 == OP_RD_PIX) && col_ok_s1 && word[bit_s1];
	assign dl_bit = info_s1.strobe && cur_word[info_s1.dl_pos];
	assign dh_bit = info_s1.strobe && info_s1.dh_ok && cur_word[info_s1.dh_pos];

	// Hold the column being shifted; load it on its first tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (s1_adv && info_s1.load) begin
			shift_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_bit_q  <= rd_bit;
			serial_lo_q <= dl_bit;
			serial_hi_q <= dh_bit;
			strobe_q    <= info_s1.strobe;
			latch_q     <= info_s1.latch;
			enable_q    <= info_s1.enable;
			busy_q      <= info_s1.busy;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.read_bit      = read_bit_q;
	assign res.serial_lo     = serial_lo_q;
	assign res.serial_hi     = serial_hi_q;
	assign res.shift_strobe  = strobe_q;
	assign res.latch_level   = latch_q;
	assign res.output_enable = enable_q;
	assign res.busy_res      = busy_q;
endmodule

FILE: sv/lcfs_checker.sv
`include "assert_macros.svh"

module lcfs_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic read_bit,
	input logic serial_lo,
	input logic serial_hi,
	input logic shift_strobe,
	input logic latch_level,
	input logic output_enable,
	input logic busy_res
);
	logic [6:0] payload;

	assign payload = {read_bit, serial_lo, serial_hi, shift_strobe, latch_level,
		output_enable, busy_res};

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, $stable(payload))
	`ASSERT_IMPLY(a_busy_latch_low, clk, arst_n, res_valid && busy_res, !latch_level)
	`ASSERT_IMPLY(a_quiet_data, clk, arst_n, res_valid && !shift_strobe, !serial_lo && !serial_hi)
	`ASSERT_IMPLY(a_strobe_enable, clk, arst_n, res_valid && shift_strobe, output_enable)
	`ASSERT_IMPLY(a_last_bit_latch, clk, arst_n, res_valid && shift_strobe && !busy_res,
		latch_level)
endmodule

bind led_column_frame_shifter_unit lcfs_checker u_lcfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.read_bit     (res.read_bit),
	.serial_lo    (res.serial_lo),
	.serial_hi    (res.serial_hi),
	.shift_strobe (res.shift_strobe),
	.latch_level  (res.latch_level),
	.output_enable(res.output_enable),
	.busy_res     (res.busy_res)
);
